// ===== rtl/core/trle_pkg.sv =====
// Shared types, constants and pixel helpers for the TGA run-length encoder.
package trle_pkg;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_COMPRESS_ENABLE = 2'd2
    } cfg_index_t;

    localparam int          DIM_W         = 16;
    localparam int          PIX_W         = 32;
    localparam int          HDR_W         = 8;
    localparam int          HDR_LEN_W     = 7;
    localparam logic        HDR_RUN_FLAG  = 1'b1;
    localparam logic [7:0]  HDR_SINGLE    = 8'h00;

    typedef struct packed {
        logic [HDR_W-1:0] packet_header;
        logic             header_valid;
        logic [PIX_W-1:0] pixel_bgra;
        logic             image_done;
    } result_t;

    function automatic logic [PIX_W-1:0] to_bgra(input logic [PIX_W-1:0] p);
        return {p[31:24], p[7:0], p[15:8], p[23:16]};
    endfunction

endpackage

// ===== rtl/core/tga_rle_pixel_encoder.sv =====
// Top level of the TGA run-length pixel encoder.
//
//   channel   | direction | handshake           | payload
//   s_        | in        | s_valid / s_ready   | s_pixel_rgba
//   m_        | out       | m_valid / m_ready   | header, header valid, BGRA pixel, done
//   cfg_      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle while s_ready is high; its results land in the queue at the accepting edge.
// A pixel can make two results, so a stretch of such pixels runs at the
// output's rate of one result per cycle; s_ready drops when fewer than two
// queue slots are free. Configuration writes are always accepted (cfg_ready is tied high).
// Reset clears the run, the counters and the queue; registers return to
// width 1, height 1, compression on.
module tga_rle_pixel_encoder #(
    parameter int MAX_RUN = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [31:0]                 s_pixel_rgba,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_packet_header,
    output logic                        m_header_valid,
    output logic [31:0]                 m_pixel_bgra,
    output logic                        m_image_done,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  trle_pkg::cfg_index_t        cfg_index,
    input  logic [trle_pkg::DIM_W-1:0]  cfg_data
);
    import trle_pkg::*;

    localparam int                RUN_W   = $clog2(MAX_RUN + 1);
    localparam logic [RUN_W-1:0]  RUN_MAX = RUN_W'(MAX_RUN);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic             compress_reg;
    logic [PIX_W-1:0] held_reg, held_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;

    logic             accept;
    logic             row_end, img_end;
    logic             extend, flush_old, close_run;
    logic [RUN_W-1:0] new_run;
    logic [1:0]       push_cnt;
    result_t          res_a, res_b, push0, push1, out_data;
    logic             room;

    function automatic logic [HDR_W-1:0] run_header(input logic [RUN_W-1:0] n);
        logic [RUN_W-1:0] n_m1;
        n_m1 = n - RUN_W'(1);
        return (n >= RUN_W'(2)) ? {HDR_RUN_FLAG, HDR_LEN_W'(n_m1)} : HDR_SINGLE;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = room;
    assign accept    = s_valid && s_ready;

    always_comb begin
        row_end   = ({1'b0, col_reg} + 17'd1) >= {1'b0, width_reg};
        img_end   = row_end && (({1'b0, row_reg} + 17'd1) >= {1'b0, height_reg});
        extend    = (run_reg != '0) && (s_pixel_rgba == held_reg) && (run_reg < RUN_MAX);
        flush_old = !extend && (run_reg != '0);
        new_run   = extend ? run_reg + RUN_W'(1) : RUN_W'(1);
        close_run = row_end || (new_run >= RUN_MAX);

        res_a.packet_header = run_header(run_reg);
        res_a.header_valid  = 1'b1;
        res_a.pixel_bgra    = to_bgra(held_reg);
        res_a.image_done    = 1'b0;

        if (row_end) begin
            col_next = '0;
            row_next = img_end ? '0 : row_reg + DIM_W'(1);
        end else begin
            col_next = col_reg + DIM_W'(1);
            row_next = row_reg;
        end

        if (!compress_reg) begin
            res_b.packet_header = HDR_SINGLE;
            res_b.header_valid  = 1'b0;
            res_b.pixel_bgra    = to_bgra(s_pixel_rgba);
            res_b.image_done    = img_end;
            held_next = held_reg;
            run_next  = '0;
            push_cnt  = {1'b0, run_reg != '0} + 2'd1;
        end else begin
            held_next = extend ? held_reg : s_pixel_rgba;
            res_b.packet_header = run_header(new_run);
            res_b.header_valid  = 1'b1;
            res_b.pixel_bgra    = to_bgra(held_next);
            res_b.image_done    = img_end;
            run_next  = close_run ? '0 : new_run;
            push_cnt  = {1'b0, flush_old} + {1'b0, close_run};
        end

        if (!accept) begin
            push_cnt = 2'd0;
        end

        if ((run_reg != '0) && (!compress_reg || flush_old)) begin
            push0 = res_a;
        end else begin
            push0 = res_b;
        end
        push1 = res_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(1);
            height_reg   <= DIM_W'(1);
            compress_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:     width_reg    <= cfg_data;
                CFG_IMAGE_HEIGHT:    height_reg   <= cfg_data;
                CFG_COMPRESS_ENABLE: compress_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            run_reg  <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else if (accept) begin
            held_reg <= held_next;
            run_reg  <= run_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    trle_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_packet_header = out_data.packet_header;
    assign m_header_valid  = out_data.header_valid;
    assign m_pixel_bgra    = out_data.pixel_bgra;
    assign m_image_done    = out_data.image_done;

`ifndef SYNTHESIS
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg < RUN_MAX)
        else $error("held run reached cap without flush");

    a_raw_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !compress_reg |=> run_reg == '0)
        else $error("run held after raw pixel");

    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && row_end |=> col_reg == '0 && run_reg == '0)
        else $error("row end did not close run and column");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt == 2'd2 |-> !push0.image_done)
        else $error("image done on flushed run");
`endif

endmodule

// ===== rtl/core/trle_out_fifo.sv =====
// Four-entry result queue taking up to two items per cycle and giving one.
module trle_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  trle_pkg::result_t push0,
    input  trle_pkg::result_t push1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output trle_pkg::result_t out_data
);
    import trle_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rptr_reg];
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb begin
        wptr_next  = wptr_reg + PTR_W'(push_cnt);
        rptr_next  = rptr_reg + PTR_W'(pop);
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wptr_reg + PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> room)
        else $error("push without room");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg - $past(count_reg)
                  == CNT_W'($past(push_cnt)) - CNT_W'($past(pop))))
        else $error("queue count out of step");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(DEPTH)) |->
            (CNT_W'(PTR_W'(wptr_reg - rptr_reg)) == count_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== bench/tga_rle_pixel_encoder_checker.sv =====
// Run-length packet predictor and result checker for the TGA pixel encoder.
`timescale 1ns / 1ps

module tga_rle_pixel_encoder_checker #(
    parameter int MAX_RUN = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [31:0]                 s_pixel_rgba,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [7:0]                  m_packet_header,
    input  logic                        m_header_valid,
    input  logic [31:0]                 m_pixel_bgra,
    input  logic                        m_image_done,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  trle_pkg::cfg_index_t        cfg_index,
    input  logic [trle_pkg::DIM_W-1:0]  cfg_data,
    input  logic                        stream_done,
    output int                          failures,
    output int                          results_pending
);
    import trle_pkg::*;

    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        compress_on;

    logic [31:0] run_pixel;
    logic [7:0]  run_count;
    logic [15:0] col;
    logic [15:0] row;

    result_t packets_due[$];
    int      mismatches = 0;
    int      results_seen = 0;
    bit      leftover_checked = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [31:0] rgba_to_bgra(input logic [31:0] p);
        return (p & 32'hFF00_FF00) | {8'h00, p[7:0], 16'h0000} | {24'h000000, p[23:16]};
    endfunction

    function automatic logic [7:0] run_header(input logic [7:0] n);
        return (n >= 8'd2) ? (8'h80 | ((n - 8'd1) & 8'h7F)) : HDR_SINGLE;
    endfunction

    task automatic queue_packet(input logic [7:0] hdr, input logic hv,
                                input logic [31:0] rgba, input logic done);
        result_t r;
        r.packet_header = hdr;
        r.header_valid  = hv;
        r.pixel_bgra    = rgba_to_bgra(rgba);
        r.image_done    = done;
        packets_due.push_back(r);
    endtask

    task automatic encode_pixel(input logic [31:0] pix);
        logic row_end;
        logic img_end;
        row_end = ({1'b0, col} + 17'd1) >= {1'b0, width_reg};
        img_end = row_end && (({1'b0, row} + 17'd1) >= {1'b0, height_reg});
        if (row_end) begin
            col = '0;
            row = img_end ? '0 : row + 16'd1;
        end else begin
            col = col + 16'd1;
        end
        if (!compress_on) begin
            if (run_count != 0) begin
                queue_packet(run_header(run_count), 1'b1, run_pixel, 1'b0);
                run_count = '0;
            end
            queue_packet(HDR_SINGLE, 1'b0, pix, img_end);
        end else begin
            if (run_count != 0 && pix == run_pixel && run_count < MAX_RUN) begin
                run_count = run_count + 8'd1;
            end else begin
                if (run_count != 0)
                    queue_packet(run_header(run_count), 1'b1, run_pixel, 1'b0);
                run_pixel = pix;
                run_count = 8'd1;
            end
            if (row_end || run_count >= MAX_RUN) begin
                queue_packet(run_header(run_count), 1'b1, run_pixel, img_end);
                run_count = '0;
            end
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            width_reg   = 16'd1;
            height_reg  = 16'd1;
            compress_on = 1'b1;
            run_pixel   = '0;
            run_count   = '0;
            col         = '0;
            row         = '0;
            packets_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (packets_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d unexpected: hdr %02h pix %08h",
                                              results_seen, m_packet_header, m_pixel_bgra));
                end else begin
                    want = packets_due.pop_front();
                    if (m_packet_header !== want.packet_header)
                        report_mismatch($sformatf("result %0d header %02h, expected %02h",
                                                  results_seen, m_packet_header,
                                                  want.packet_header));
                    if (m_header_valid !== want.header_valid)
                        report_mismatch($sformatf("result %0d header_valid %b, expected %b",
                                                  results_seen, m_header_valid,
                                                  want.header_valid));
                    if (m_pixel_bgra !== want.pixel_bgra)
                        report_mismatch($sformatf("result %0d pixel %08h, expected %08h",
                                                  results_seen, m_pixel_bgra,
                                                  want.pixel_bgra));
                    if (m_image_done !== want.image_done)
                        report_mismatch($sformatf("result %0d image_done %b, expected %b",
                                                  results_seen, m_image_done,
                                                  want.image_done));
                end
            end
            if (s_valid && s_ready)
                encode_pixel(s_pixel_rgba);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:     width_reg   = cfg_data;
                    CFG_IMAGE_HEIGHT:    height_reg  = cfg_data;
                    CFG_COMPRESS_ENABLE: compress_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (stream_done && !leftover_checked) begin
                leftover_checked = 1;
                if (packets_due.size() != 0)
                    report_mismatch($sformatf("%0d expected results never came",
                                              packets_due.size()));
            end
        end
        failures        <= mismatches;
        results_pending <= packets_due.size();
    end

endmodule

// ===== bench/tga_rle_pixel_encoder_tb.sv =====
// Stimulus, clock, reset and verdict for the TGA run-length pixel encoder.
`timescale 1ns / 1ps

module tga_rle_pixel_encoder_tb;
    import trle_pkg::*;

    localparam int RUN_CAP       = 128;
    localparam int PIXEL_TARGET  = 1100;
    localparam int CALM_TAIL     = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [31:0]       s_pixel_rgba = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_packet_header;
    logic              m_header_valid;
    logic [31:0]       m_pixel_bgra;
    logic              m_image_done;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_index_t        cfg_index = CFG_IMAGE_WIDTH;
    logic [DIM_W-1:0]  cfg_data = '0;

    logic              stream_done = 1'b0;
    logic              calm = 1'b0;
    logic              sink_stalls = 1'b1;
    bit                source_gaps = 1;
    int                failures;
    int                results_pending;
    int                pixels_sent = 0;
    int                idle_cycles = 0;
    int                hold_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tga_rle_pixel_encoder #(
        .MAX_RUN(RUN_CAP)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_rgba    (s_pixel_rgba),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_header (m_packet_header),
        .m_header_valid  (m_header_valid),
        .m_pixel_bgra    (m_pixel_bgra),
        .m_image_done    (m_image_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    tga_rle_pixel_encoder_checker #(
        .MAX_RUN(RUN_CAP)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_rgba    (s_pixel_rgba),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_header (m_packet_header),
        .m_header_valid  (m_header_valid),
        .m_pixel_bgra    (m_pixel_bgra),
        .m_image_done    (m_image_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .stream_done     (stream_done),
        .failures        (failures),
        .results_pending (results_pending)
    );

    // stall the result channel in random bursts
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0)
            sink_stalls <= ~sink_stalls;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!calm && sink_stalls && $urandom_range(0, 5) == 0) begin
            m_ready   <= 1'b0;
            hold_left <= $urandom_range(0, 7);
        end else begin
            m_ready   <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge aclk);
        $display("tga_rle_pixel_encoder_tb: FAIL");
        $finish;
    end

    task automatic send_pixel(input logic [31:0] pix);
        if (!calm && source_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pixel_rgba <= pix;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pixels_sent++;
    endtask

    task automatic send_run(input logic [31:0] pix, input int count);
        repeat (count) send_pixel(pix);
    endtask

    // hold input until every expected result is out
    task automatic drain();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic en);
        logic [15:0] en_word;
        en_word = 16'($urandom);
        en_word[0] = en;
        drain();
        put_reg(CFG_IMAGE_WIDTH, w);
        put_reg(CFG_IMAGE_HEIGHT, h);
        put_reg(CFG_COMPRESS_ENABLE, en_word);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] palette [4];
        logic [31:0] run_px;
        logic [15:0] w;
        logic [15:0] h;
        logic        en;
        int          left;
        int          len;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: each pixel is a whole image
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h80FF_0001);

        // runs, flush order at row end, image end
        configure(16'd4, 16'd2, 1'b1);
        send_run(32'h1122_3344, 3);
        send_pixel(32'h5566_7788);
        send_pixel(32'hA5A5_A5A5);
        send_run(32'h0102_0304, 3);

        // switch to raw with a run held
        configure(16'd3, 16'd1, 1'b1);
        send_run(32'hDEAD_BEEF, 2);
        configure(16'd3, 16'd1, 1'b0);
        send_pixel(32'h1357_9BDF);
        send_pixel(32'h0000_00FF);
        send_pixel(32'h00FF_0000);
        send_pixel(32'hFF00_FF00);

        // zero width and height
        configure(16'd0, 16'd0, 1'b1);
        send_run(32'h7777_7777, 2);

        // shrink the row mid-image
        configure(16'd8, 16'd4, 1'b1);
        send_run(32'h2468_ACE0, 3);
        send_run(32'h0F0F_0F0F, 2);
        configure(16'd3, 16'd4, 1'b1);
        send_pixel(32'h0F0F_0F0F);
        send_pixel(32'hF0F0_F0F0);

        // run cap, exactly and one past
        configure(16'hFFFF, 16'hFFFF, 1'b1);
        send_run(32'hCAFE_F00D, RUN_CAP);
        send_run(32'h0BAD_C0DE, RUN_CAP + 1);

        while (pixels_sent < PIXEL_TARGET) begin
            if (pixels_sent >= PIXEL_TARGET - CALM_TAIL)
                calm <= 1'b1;
            case ($urandom_range(0, 7))
                0: begin
                    w = 16'hFFFF;
                    h = 16'($urandom_range(1, 3));
                end
                1: begin
                    w = 16'($urandom_range(1, 4));
                    h = 16'hFFFF;
                end
                2: begin
                    w = 16'd0;
                    h = 16'($urandom_range(0, 2));
                end
                default: begin
                    w = 16'($urandom_range(1, 12));
                    h = 16'($urandom_range(1, 6));
                end
            endcase
            en = ($urandom_range(0, 3) != 0);
            configure(w, h, en);
            source_gaps = ($urandom_range(0, 3) != 0);
            palette[0] = 32'h0000_0000;
            palette[1] = 32'hFFFF_FFFF;
            palette[2] = $urandom;
            palette[3] = $urandom;
            run_px = $urandom;
            left = $urandom_range(10, 120);
            while (left > 0) begin
                case ($urandom_range(0, 3))
                    0: run_px = $urandom;
                    1: run_px = run_px ^ (32'h1 << $urandom_range(0, 31));
                    default: run_px = palette[2'($urandom_range(0, 3))];
                endcase
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 6);
                if (len > left)
                    len = left;
                send_run(run_px, len);
                left -= len;
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end

        drain();
        stream_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (failures == 0)
            $display("tga_rle_pixel_encoder_tb: PASS");
        else
            $display("tga_rle_pixel_encoder_tb: FAIL");
        $finish;
    end

endmodule
